### hdl/dmul_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmul_pkg;

   localparam int PAIR_LIMIT = 32;
   localparam int IDX_W      = $clog2(PAIR_LIMIT);
   localparam int CNT_W      = $clog2(PAIR_LIMIT + 1);
   localparam int STEP_W     = $clog2(2 * PAIR_LIMIT);
   localparam int DIGIT_W    = 4;
   localparam int PROD_W     = 2 * DIGIT_W;
   localparam int COL_W      = 12;
   localparam int CARRY_W    = 9;
   localparam int RADIX      = 10;
   localparam int MAX_DIGIT  = 9;
   localparam int DIV_MULT   = 6554;
   localparam int DIV_SHIFT  = 16;
   localparam int DIV_PROD_W = 25;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_a;
      logic [DIGIT_W-1:0] digit_b;
      logic               last_pair;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] product_digit;
      logic               last_digit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic first;
      logic clr_acc;
      logic step;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_RUN
   } state_type;

   function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
      clamp_digit = (d > DIGIT_W'(MAX_DIGIT)) ? DIGIT_W'(MAX_DIGIT) : d;
   endfunction

endpackage

`default_nettype wire

### hdl/dmul_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dmul_cell (
   input  wire logic                              clock,
   input  wire dmul_pkg::cell_ctrl_type           ctrl,
   input  wire logic                              sel,
   input  wire logic [dmul_pkg::DIGIT_W-1:0]      din_a,
   input  wire logic [dmul_pkg::DIGIT_W-1:0]      din_b,
   input  wire logic [dmul_pkg::DIGIT_W-1:0]      b_up,
   input  wire logic [dmul_pkg::COL_W-1:0]        acc_up,
   input  wire logic [dmul_pkg::DIGIT_W-1:0]      b_bcast,
   output logic      [dmul_pkg::DIGIT_W-1:0]      b_out,
   output logic      [dmul_pkg::COL_W-1:0]        col_out
);

   logic [dmul_pkg::DIGIT_W-1:0] a_ff, a_in;
   logic [dmul_pkg::DIGIT_W-1:0] b_ff, b_in;
   logic [dmul_pkg::COL_W-1:0]   acc_ff, acc_in;
   logic [dmul_pkg::PROD_W-1:0]  prod;

   assign prod    = dmul_pkg::PROD_W'(a_ff) * dmul_pkg::PROD_W'(b_bcast);
   assign col_out = acc_ff + dmul_pkg::COL_W'(prod);
   assign b_out   = b_ff;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.load && sel) begin
         a_in = din_a;
         b_in = din_b;
      end else if (ctrl.load && ctrl.first) begin
         a_in = '0;
         b_in = '0;
      end else if (ctrl.step) begin
         b_in = b_up;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clr_acc) begin
         acc_in = '0;
      end else if (ctrl.step) begin
         acc_in = acc_up;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

### hdl/decimal_digit_multiplier.sv
`timescale 1ns / 1ps
`default_nettype none

// Decimal digit multiplier.
// Input channel (req_): one digit pair per transaction, least significant
// first; digits above nine are stored as nine. The pair flagged last_pair
// ends the operand and starts the multiplication. Pairs past the 32nd are
// dropped, but a dropped last_pair still starts the run.
// Result channel (rsp_): 2n product digits for n stored pairs, least
// significant first, last_digit set on the final one.
// A row of 32 cells holds the digits and the column sums; each run step adds
// one digit of B times all of A into the row and shifts one finished column
// out, so a run takes 2n steps. After the last pair, the first digit passes
// through the column register and the output register; digits then follow
// one per cycle while the receiver is ready.
// req_ready is low while a run is stepping. A stalled receiver holds the
// output register and freezes the row; nothing is lost.
// Reset empties the pipeline and returns to loading; digit cells need no reset.

module decimal_digit_multiplier (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dmul_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dmul_pkg::rsp_type      rsp_data
);

   localparam int N = dmul_pkg::PAIR_LIMIT;

   dmul_pkg::state_type     state_ff, state_in;
   dmul_pkg::cell_ctrl_type ctrl;

   logic [dmul_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [dmul_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [dmul_pkg::STEP_W-1:0]  t_ff, t_in;
   logic                         col_vld_ff, col_vld_in;
   logic [dmul_pkg::COL_W-1:0]   col_ff;
   logic                         col_last_ff;
   logic [dmul_pkg::CARRY_W-1:0] carry_ff, carry_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dmul_pkg::rsp_type            rsp_ff;

   logic                            accept, has_room, step, final_step, norm_move;
   logic [dmul_pkg::STEP_W:0]       step_end;
   logic [dmul_pkg::COL_W-1:0]      norm_v;
   logic [dmul_pkg::DIV_PROD_W-1:0] div_prod;
   logic [dmul_pkg::CARRY_W-1:0]    norm_q;
   logic [dmul_pkg::COL_W-1:0]      norm_r;
   logic [dmul_pkg::DIGIT_W-1:0]    din_a, din_b;

   logic [dmul_pkg::DIGIT_W-1:0] b_link   [N+1];
   logic [dmul_pkg::COL_W-1:0]   col_link [N+1];

   assign accept     = req_valid && req_ready;
   assign has_room   = count_ff < dmul_pkg::CNT_W'(N);
   assign step_end   = ({1'b0, dmul_pkg::STEP_W'(n_ff)} << 1) -
                       (dmul_pkg::STEP_W + 1)'(1);
   assign final_step = ({1'b0, t_ff} == step_end);
   assign norm_move  = col_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign din_a      = dmul_pkg::clamp_digit(req_data.digit_a);
   assign din_b      = dmul_pkg::clamp_digit(req_data.digit_b);

   assign ctrl.load    = accept && has_room;
   assign ctrl.first   = (count_ff == '0);
   assign ctrl.clr_acc = accept && req_data.last_pair;
   assign ctrl.step    = step;

   assign b_link[N]   = '0;
   assign col_link[N] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      dmul_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .sel     (count_ff[dmul_pkg::IDX_W-1:0] == dmul_pkg::IDX_W'(i)),
         .din_a   (din_a),
         .din_b   (din_b),
         .b_up    (b_link[i+1]),
         .acc_up  (col_link[i+1]),
         .b_bcast (b_link[0]),
         .b_out   (b_link[i]),
         .col_out (col_link[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmul_pkg::ST_LOAD: begin
            if (req_valid && req_data.last_pair) begin
               state_in = dmul_pkg::ST_RUN;
            end
         end
         dmul_pkg::ST_RUN: begin
            if (step && final_step) begin
               state_in = dmul_pkg::ST_LOAD;
            end
         end
         default: state_in = dmul_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      step      = 1'b0;
      unique case (state_ff)
         dmul_pkg::ST_LOAD: req_ready = 1'b1;
         dmul_pkg::ST_RUN:  step      = !col_vld_ff || norm_move;
         default: begin
            req_ready = 1'b0;
            step      = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      if (accept) begin
         if (req_data.last_pair) begin
            count_in = '0;
            n_in     = count_ff + dmul_pkg::CNT_W'(has_room);
         end else if (has_room) begin
            count_in = count_ff + dmul_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      t_in = t_ff;
      if (ctrl.clr_acc) begin
         t_in = '0;
      end else if (step) begin
         t_in = t_ff + dmul_pkg::STEP_W'(1);
      end
   end

   // base-10 normalize: quotient by reciprocal multiply, exact below 2**14
   assign norm_v   = col_ff + dmul_pkg::COL_W'(carry_ff);
   assign div_prod = dmul_pkg::DIV_PROD_W'(norm_v) *
                     dmul_pkg::DIV_PROD_W'(dmul_pkg::DIV_MULT);
   assign norm_q   = div_prod[dmul_pkg::DIV_SHIFT +: dmul_pkg::CARRY_W];
   assign norm_r   = norm_v - dmul_pkg::COL_W'(norm_q) * dmul_pkg::COL_W'(dmul_pkg::RADIX);

   always_comb begin
      col_vld_in = col_vld_ff;
      if (step) begin
         col_vld_in = 1'b1;
      end else if (norm_move) begin
         col_vld_in = 1'b0;
      end
   end

   always_comb begin
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      if (norm_move) begin
         carry_in     = col_last_ff ? '0 : norm_q;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmul_pkg::ST_LOAD;
         count_ff     <= '0;
         n_ff         <= '0;
         t_ff         <= '0;
         col_vld_ff   <= 1'b0;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         t_ff         <= t_in;
         col_vld_ff   <= col_vld_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         col_ff      <= col_link[0];
         col_last_ff <= final_step;
      end
      if (norm_move) begin
         rsp_ff.product_digit <= norm_r[dmul_pkg::DIGIT_W-1:0];
         rsp_ff.last_digit    <= col_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hdl/dmul_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dmul_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire dmul_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire dmul_pkg::rsp_type rsp_data
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result dropped or changed under stall");

   property p_digit_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_data.product_digit <= dmul_pkg::DIGIT_W'(dmul_pkg::MAX_DIGIT);
   endproperty
   a_digit_range: assert property (p_digit_range)
      else $error("product digit above nine");

   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("result valid after reset");

   property p_run_blocks_load;
      @(posedge clock) disable iff (reset)
         req_valid && req_ready && req_data.last_pair |=> !req_ready;
   endproperty
   a_run_blocks_load: assert property (p_run_blocks_load)
      else $error("input taken right after last pair");

endmodule

bind decimal_digit_multiplier dmul_checker u_dmul_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### bench/tb_decimal_digit_multiplier.sv
`timescale 1ns / 1ps

module tb_decimal_digit_multiplier;

   class product_predictor;
      logic [dmul_pkg::DIGIT_W-1:0] digits_a [dmul_pkg::PAIR_LIMIT];
      logic [dmul_pkg::DIGIT_W-1:0] digits_b [dmul_pkg::PAIR_LIMIT];
      int unsigned                  pairs_held;
      dmul_pkg::rsp_type            expected_digits [$];
      int unsigned                  mismatch_count;

      function new();
         pairs_held     = 0;
         mismatch_count = 0;
      endfunction

      function automatic logic [dmul_pkg::DIGIT_W-1:0] saturate(
         input logic [dmul_pkg::DIGIT_W-1:0] d);
         return (d > dmul_pkg::DIGIT_W'(dmul_pkg::MAX_DIGIT)) ?
                dmul_pkg::DIGIT_W'(dmul_pkg::MAX_DIGIT) : d;
      endfunction

      function void load_pair(input dmul_pkg::req_type pair);
         int unsigned       sums [2*dmul_pkg::PAIR_LIMIT];
         int unsigned       carry;
         int unsigned       v;
         dmul_pkg::rsp_type digit;
         if (pairs_held < dmul_pkg::PAIR_LIMIT) begin
            digits_a[pairs_held] = saturate(pair.digit_a);
            digits_b[pairs_held] = saturate(pair.digit_b);
            pairs_held++;
         end
         if (!pair.last_pair) return;
         foreach (sums[k]) sums[k] = 0;
         for (int i = 0; i < pairs_held; i++)
            for (int j = 0; j < pairs_held; j++)
               sums[i+j] += int'(digits_a[i]) * int'(digits_b[j]);
         carry = 0;
         for (int i = 0; i < 2 * pairs_held; i++) begin
            v = sums[i] + carry;
            carry = v / dmul_pkg::RADIX;
            digit.product_digit = dmul_pkg::DIGIT_W'(v % dmul_pkg::RADIX);
            digit.last_digit    = (i + 1 == 2 * pairs_held);
            expected_digits.push_back(digit);
         end
         pairs_held = 0;
      endfunction

      function void check_digit(input dmul_pkg::rsp_type actual);
         dmul_pkg::rsp_type want;
         if (expected_digits.size() == 0) begin
            $error("product digit %0d with no transaction pending", actual.product_digit);
            mismatch_count++;
            return;
         end
         want = expected_digits.pop_front();
         if (actual.product_digit !== want.product_digit) begin
            $error("product_digit expected %0d actual %0d",
                   want.product_digit, actual.product_digit);
            mismatch_count++;
         end
         if (actual.last_digit !== want.last_digit) begin
            $error("last_digit expected %0d actual %0d", want.last_digit, actual.last_digit);
            mismatch_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_digits.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dmul_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dmul_pkg::rsp_type rsp_data;

   product_predictor board = new();
   int unsigned      pairs_sent = 0;
   bit               quiet = 1'b0;
   bit               hold_off_done = 1'b0;

   decimal_digit_multiplier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.load_pair(req_data);
         if (rsp_valid && rsp_ready) board.check_digit(rsp_data);
      end
   end

   task automatic send_pair(input logic [dmul_pkg::DIGIT_W-1:0] a,
                            input logic [dmul_pkg::DIGIT_W-1:0] b,
                            input logic last);
      dmul_pkg::req_type pair;
      pair.digit_a   = a;
      pair.digit_b   = b;
      pair.last_pair = last;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (!req_ready);
      pairs_sent++;
      if (pairs_sent >= 300) quiet = 1'b1;
   endtask

   function automatic logic [dmul_pkg::DIGIT_W-1:0] pick_digit(input int unsigned flavor);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (flavor == 1) return dmul_pkg::DIGIT_W'(dmul_pkg::MAX_DIGIT);
      if (roll < 10) return dmul_pkg::DIGIT_W'($urandom_range(10, 15));
      if (roll < 20) return dmul_pkg::DIGIT_W'(dmul_pkg::MAX_DIGIT);
      return dmul_pkg::DIGIT_W'($urandom_range(0, 9));
   endfunction

   task automatic send_operand(input int unsigned len, input int unsigned flavor);
      for (int unsigned k = 0; k < len; k++)
         send_pair(pick_digit(flavor), pick_digit(flavor), k + 1 == len);
   endtask

   initial begin
      int unsigned len;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_pair(4'd0, 4'd0, 1'b1);
      send_pair(4'd9, 4'd9, 1'b1);
      send_pair(4'd15, 4'd15, 1'b1);
      send_pair(4'd10, 4'd9, 1'b0);
      send_pair(4'd14, 4'd11, 1'b1);
      send_pair(4'd9, 4'd0, 1'b0);
      send_pair(4'd0, 4'd9, 1'b1);
      send_pair(4'd1, 4'd2, 1'b0);
      send_pair(4'd3, 4'd4, 1'b0);
      send_pair(4'd5, 4'd6, 1'b1);
      send_pair(4'd8, 4'd7, 1'b0);
      send_pair(4'd6, 4'd5, 1'b0);
      send_pair(4'd4, 4'd3, 1'b0);
      send_pair(4'd2, 4'd1, 1'b1);
      send_pair(4'd12, 4'd9, 1'b0);
      send_pair(4'd9, 4'd13, 1'b0);
      send_pair(4'd11, 4'd15, 1'b0);
      send_pair(4'd0, 4'd0, 1'b0);
      send_pair(4'd7, 4'd8, 1'b1);

      send_operand(dmul_pkg::PAIR_LIMIT, 1);
      send_operand(dmul_pkg::PAIR_LIMIT + 4, 0);

      while (pairs_sent < 360) begin
         if ($urandom_range(0, 99) < 4)
            len = $urandom_range(dmul_pkg::PAIR_LIMIT - 2, dmul_pkg::PAIR_LIMIT + 6);
         else len = $urandom_range(1, 8);
         send_operand(len, ($urandom_range(0, 19) == 0) ? 1 : 0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned gap;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_off_done && pairs_sent >= 120) begin
            rsp_ready     <= 1'b0;
            hold_off_done = 1'b1;
            repeat (400) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
hdl/dmul_pkg.sv
hdl/dmul_cell.sv
hdl/decimal_digit_multiplier.sv
hdl/dmul_checker.sv
bench/tb_decimal_digit_multiplier.sv
